>>> hdl/kda_pkg.sv
`timescale 1ns / 1ps

package kda_pkg;

  // field widths
  localparam int KEY_W  = 3;
  localparam int TICK_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // key tracking states
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_t;

  // register indexes, taken from paddr word address
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd500;
  localparam logic [TICK_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [TICK_W-1:0] SETTLE_RST   = 16'd50;

  // timing settings handed from the register block to the engine
  typedef struct packed {
    logic [TICK_W-1:0] repeat_timeout;
    logic [TICK_W-1:0] repeat_interval;
    logic [TICK_W-1:0] settle_delay;
  } cfg_t;

  // one registered poll
  typedef struct packed {
    logic [KEY_W-1:0]  keys;
    logic [TICK_W-1:0] now;
  } poll_t;

endpackage

>>> hdl/kda_cfg_regs.sv
`timescale 1ns / 1ps

module kda_cfg_regs
  import kda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  logic [TICK_W-1:0] interval_r, interval_nxt;
  logic [TICK_W-1:0] settle_r, settle_nxt;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // write decode, unknown index is dropped
  always_comb begin
    timeout_nxt  = timeout_r;
    interval_nxt = interval_r;
    settle_nxt   = settle_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT:  timeout_nxt  = pwdata[TICK_W-1:0];
        REG_INTERVAL: interval_nxt = pwdata[TICK_W-1:0];
        REG_SETTLE:   settle_nxt   = pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      interval_r <= INTERVAL_RST;
      settle_r   <= SETTLE_RST;
    end else begin
      timeout_r  <= timeout_nxt;
      interval_r <= interval_nxt;
      settle_r   <= settle_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TIMEOUT:  prdata = {{(DATA_W-TICK_W){1'b0}}, timeout_r};
      REG_INTERVAL: prdata = {{(DATA_W-TICK_W){1'b0}}, interval_r};
      REG_SETTLE:   prdata = {{(DATA_W-TICK_W){1'b0}}, settle_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.repeat_timeout  = timeout_r;
  assign cfg.repeat_interval = interval_r;
  assign cfg.settle_delay    = settle_r;

endmodule

>>> hdl/kda_engine.sv
`timescale 1ns / 1ps

module kda_engine
  import kda_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             poll_vld,
  input  poll_t            poll,
  output logic             poll_take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] out_keys,
  output logic             out_hold
);

  mode_t             mode_r, mode_nxt;
  logic [KEY_W-1:0]  last_keys_r, last_keys_nxt;
  logic [TICK_W-1:0] press_start_r, press_start_nxt;
  logic [TICK_W-1:0] lock_start_r, lock_start_nxt;
  logic [TICK_W-1:0] lock_len_r, lock_len_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [KEY_W-1:0]  out_keys_r;
  logic              out_hold_r;
  logic [TICK_W-1:0] lock_elapsed;
  logic [TICK_W-1:0] press_elapsed;
  logic              lock_busy;
  logic [KEY_W-1:0]  rep;
  logic              rep_hold;

  // a poll moves on when the result register is free or being drained
  assign poll_take = poll_vld & (~out_vld_r | out_ready);

  // wrapping elapsed times
  assign lock_elapsed  = poll.now - lock_start_r;
  assign press_elapsed = poll.now - press_start_r;
  assign lock_busy     = (lock_len_r != '0) && (lock_elapsed < lock_len_r);

  // next state and report
  always_comb begin
    mode_nxt        = mode_r;
    last_keys_nxt   = last_keys_r;
    press_start_nxt = press_start_r;
    lock_start_nxt  = lock_start_r;
    lock_len_nxt    = lock_len_r;
    rep             = '0;
    rep_hold        = 1'b0;
    if (poll_take && !lock_busy) begin
      lock_len_nxt = '0;
      unique case (mode_r)
        MODE_PRESSED, MODE_REPEAT: begin
          if (poll.keys != last_keys_r) begin
            mode_nxt       = MODE_IDLE;
            lock_start_nxt = poll.now;
            lock_len_nxt   = cfg.settle_delay;
          end else if (mode_r == MODE_REPEAT ||
                       press_elapsed >= cfg.repeat_timeout) begin
            mode_nxt       = MODE_REPEAT;
            lock_start_nxt = poll.now;
            lock_len_nxt   = cfg.repeat_interval;
            rep            = poll.keys;
            rep_hold       = 1'b1;
          end
        end
        default: begin
          if (poll.keys != '0) begin
            mode_nxt        = MODE_PRESSED;
            press_start_nxt = poll.now;
            last_keys_nxt   = poll.keys;
            rep             = poll.keys;
          end
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      last_keys_r   <= '0;
      press_start_r <= '0;
      lock_start_r  <= '0;
      lock_len_r    <= '0;
    end else begin
      mode_r        <= mode_nxt;
      last_keys_r   <= last_keys_nxt;
      press_start_r <= press_start_nxt;
      lock_start_r  <= lock_start_nxt;
      lock_len_r    <= lock_len_nxt;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (poll_take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_take) begin
      out_keys_r <= rep;
      out_hold_r <= rep_hold;
    end
  end

  assign out_valid = out_vld_r;
  assign out_keys  = out_keys_r;
  assign out_hold  = out_hold_r;

endmodule

>>> hdl/keypad_debounce_auto_repeat_core.sv
`timescale 1ns / 1ps
// path: an accepted poll is held in the input register, then moves on to the result register
// throughput: one poll per cycle while out_ready is high, set by the input register feeding the result register
// result register frees itself in the cycle it is drained, so in_ready only drops on a stall
// reset: synchronous, active low; clears key state, lockout and valid flags,
// timing registers return to 500 / 100 / 50 ticks
module keypad_debounce_auto_repeat_core
  import kda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KEY_W-1:0]  in_pressed_keys,
  input  logic [TICK_W-1:0] in_now_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  out_reported_keys,
  output logic              out_hold,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  poll_t poll_r;
  logic  poll_vld_r, poll_vld_nxt;
  logic  poll_take;

  // configuration registers
  kda_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register
  assign in_ready = ~poll_vld_r | poll_take;

  always_comb begin
    poll_vld_nxt = poll_vld_r;
    if (in_valid && in_ready) begin
      poll_vld_nxt = 1'b1;
    end else if (poll_take) begin
      poll_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_vld_r <= 1'b0;
    end else begin
      poll_vld_r <= poll_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.keys <= in_pressed_keys;
      poll_r.now  <= in_now_ticks;
    end
  end

  // key state machine and result register
  kda_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .poll_vld  (poll_vld_r),
    .poll      (poll_r),
    .poll_take (poll_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_keys  (out_reported_keys),
    .out_hold  (out_hold)
  );

  // a hold report always carries a key code
  a_hold_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold |-> out_reported_keys != '0)
    else $error("hold flag with empty key code");

  // input side only stalls when the result register is blocked
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // an accepted poll is held in the input register on the next cycle
  a_poll_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> poll_vld_r)
    else $error("accepted poll lost");

endmodule
